// ===== design/sorted_word_frequency_table_defines.svh =====
// Assertion macros shared by the sorted word frequency table.
`ifndef SORTED_WORD_FREQUENCY_TABLE_DEFINES_SVH
`define SORTED_WORD_FREQUENCY_TABLE_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define SWFT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle.
`define SWFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/swft_pkg.sv =====
// ----------------------------------------------------------------------------
// swft_pkg
// Shared constants, codes and types of the sorted word frequency table.
// ----------------------------------------------------------------------------
package swft_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS    = 64;
  localparam int COUNT_BITS  = 32;
  localparam int POS_W       = $clog2(TABLE_DEPTH);
  localparam int IDX_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_COUNTED   = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_DUMP      = 3'd5;

  typedef struct packed {
    logic                  valid;
    logic [KEY_BITS-1:0]   key;
    logic [COUNT_BITS-1:0] count;
  } swft_entry_t;

  typedef struct packed {
    logic                  valid;
    logic [COUNT_BITS-1:0] count;
    logic [POS_W-1:0]      idx;
  } swft_aux_t;

  typedef struct packed {
    logic                eval;
    logic                ins;
    logic                del;
    logic                inc;
    logic                dload;
    logic                rot;
    logic [KEY_BITS-1:0] word;
  } swft_op_t;

endpackage

// ===== design/swft_cell.sv =====
// ----------------------------------------------------------------------------
// swft_cell
// One table slot: key, count, compare flags and the ranking ring stage.
// ----------------------------------------------------------------------------
module swft_cell import swft_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  swft_op_t         op_i,
  input  logic [POS_W-1:0] idx_i,
  input  swft_entry_t      left_i,
  input  swft_entry_t      right_i,
  input  logic             left_lt_i,
  input  swft_aux_t        aux_left_i,
  output logic             lt_o,
  output logic             eq_o,
  output swft_entry_t      ent_o,
  output swft_aux_t        aux_o,
  output logic [IDX_W-1:0] rank_o
);

  swft_entry_t      ent_q, ent_d;
  swft_aux_t        aux_q, aux_d;
  logic             lt_q, lt_d, eq_q, eq_d;
  logic [IDX_W-1:0] rank_q, rank_d;
  logic             ahead;

  // aux entry ranks ahead of this one: lower count, or equal count and lower slot
  assign ahead = aux_q.valid && ((aux_q.count < ent_q.count) ||
                 ((aux_q.count == ent_q.count) && (aux_q.idx < idx_i)));

  always_comb begin
    ent_d  = ent_q;
    aux_d  = aux_q;
    lt_d   = lt_q;
    eq_d   = eq_q;
    rank_d = rank_q;
    if (op_i.eval) begin
      lt_d = ent_q.valid && (ent_q.key < op_i.word);
      eq_d = ent_q.valid && (ent_q.key == op_i.word);
    end
    if (op_i.ins && !lt_q) begin
      if (left_lt_i) begin
        ent_d.valid = 1'b1;
        ent_d.key   = op_i.word;
        ent_d.count = COUNT_BITS'(1);
      end else begin
        ent_d = left_i;
      end
    end
    if (op_i.del && !lt_q) begin
      ent_d = right_i;
    end
    if (op_i.inc && eq_q && (ent_q.count != '1)) begin
      ent_d.count = ent_q.count + COUNT_BITS'(1);
    end
    if (op_i.dload) begin
      aux_d.valid = ent_q.valid;
      aux_d.count = ent_q.count;
      aux_d.idx   = idx_i;
      rank_d      = '0;
    end
    if (op_i.rot) begin
      aux_d = aux_left_i;
      if (ahead) begin
        rank_d = rank_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q  <= '0;
      aux_q  <= '0;
      lt_q   <= 1'b0;
      eq_q   <= 1'b0;
      rank_q <= '0;
    end else begin
      ent_q  <= ent_d;
      aux_q  <= aux_d;
      lt_q   <= lt_d;
      eq_q   <= eq_d;
      rank_q <= rank_d;
    end
  end

  assign lt_o   = lt_q;
  assign eq_o   = eq_q;
  assign ent_o  = ent_q;
  assign aux_o  = aux_q;
  assign rank_o = rank_q;

endmodule

// ===== design/sorted_word_frequency_table.sv =====
// ----------------------------------------------------------------------------
// sorted_word_frequency_table
// Add/remove: S_EVAL registers the compare, then S_APPLY shifts the cell row
// and registers the result; the next transfer is accepted only back in S_IDLE.
// Dump: S_DLOAD loads the rank ring and S_ROT circulates every count past every
// cell once; then S_EMIT gives one result per cycle while the output is not
// stalled. Output stalls hold the states that write the output. Asynchronous
// active-low reset empties the table (fill level zero).
// ----------------------------------------------------------------------------
`include "sorted_word_frequency_table_defines.svh"

module sorted_word_frequency_table import swft_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // word[63:0]
  input  logic [1:0]   s_axis_tuser,   // cmd[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,   // entry_word[63:0], entry_count[95:64],
                                       // entry_index[102:96], table_size[109:103], pad
  output logic [2:0]   m_axis_tuser,   // status[2:0]
  output logic         m_axis_tlast    // last
);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_DLOAD = 3'd3;
  localparam logic [2:0] S_ROT   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [1:0]          cmd_q, cmd_d;
  logic [KEY_BITS-1:0] word_q, word_d;
  logic [IDX_W-1:0]    fill_q, fill_d;
  logic [POS_W-1:0]    rot_q, rot_d;
  logic [IDX_W-1:0]    rank_sel_q, rank_sel_d;

  // Output register
  logic                  out_vld_q, out_vld_d;
  logic [2:0]            out_st_q, out_st_d;
  logic [KEY_BITS-1:0]   out_key_q, out_key_d;
  logic [COUNT_BITS-1:0] out_cnt_q, out_cnt_d;
  logic [IDX_W-1:0]      out_idx_q, out_idx_d;
  logic [IDX_W-1:0]      out_size_q, out_size_d;
  logic                  out_last_q, out_last_d;
  logic                  out_free;

  // Cell row
  swft_op_t                     op;
  swft_entry_t [TABLE_DEPTH-1:0] ent;
  swft_aux_t   [TABLE_DEPTH-1:0] aux;
  logic        [TABLE_DEPTH-1:0] lt, eq, first, hit;
  logic        [IDX_W-1:0]       rank [TABLE_DEPTH];

  // Reductions across the row
  logic                  found, any_first;
  logic [IDX_W-1:0]      first_idx, pos;
  logic [COUNT_BITS-1:0] match_cnt, inc_cnt;
  logic [KEY_BITS-1:0]   hit_key;
  logic [COUNT_BITS-1:0] hit_cnt;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    swft_entry_t left_ent, right_ent;
    logic        left_lt;
    if (g == 0) begin : g_head
      assign left_ent = '0;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_ent = ent[g-1];
      assign left_lt  = lt[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = ent[g+1];
    end
    swft_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .op_i       (op),
      .idx_i      (POS_W'(g)),
      .left_i     (left_ent),
      .right_i    (right_ent),
      .left_lt_i  (left_lt),
      .aux_left_i (aux[(g + TABLE_DEPTH - 1) % TABLE_DEPTH]),
      .lt_o       (lt[g]),
      .eq_o       (eq[g]),
      .ent_o      (ent[g]),
      .aux_o      (aux[g]),
      .rank_o     (rank[g])
    );
    // first slot whose key is not below the word
    assign first[g] = !lt[g] && left_lt;
    assign hit[g]   = ent[g].valid && (rank[g] == rank_sel_q);
  end

  // One-hot selects folded by OR
  always_comb begin
    found     = 1'b0;
    any_first = 1'b0;
    first_idx = '0;
    match_cnt = '0;
    hit_key   = '0;
    hit_cnt   = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      found     = found | eq[i];
      any_first = any_first | first[i];
      first_idx = first_idx | (first[i] ? IDX_W'(i) : '0);
      match_cnt = match_cnt | (eq[i] ? ent[i].count : '0);
      hit_key   = hit_key | (hit[i] ? ent[i].key : '0);
      hit_cnt   = hit_cnt | (hit[i] ? ent[i].count : '0);
    end
  end

  // every slot below the word means the position is past the end
  assign pos     = any_first ? first_idx : fill_q;
  assign inc_cnt = (match_cnt == '1) ? match_cnt : match_cnt + COUNT_BITS'(1);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    word_d     = word_q;
    fill_d     = fill_q;
    rot_d      = rot_q;
    rank_sel_d = rank_sel_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_st_d   = out_st_q;
    out_key_d  = out_key_q;
    out_cnt_d  = out_cnt_q;
    out_idx_d  = out_idx_q;
    out_size_d = out_size_q;
    out_last_d = out_last_q;
    op         = '0;
    op.word    = word_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d  = s_axis_tuser;
          word_d = s_axis_tdata[KEY_BITS-1:0];
          if (s_axis_tuser == CMD_ADD || s_axis_tuser == CMD_REMOVE) begin
            state_d = S_EVAL;
          end else if (s_axis_tuser == CMD_DUMP) begin
            state_d = S_DLOAD;
          end
        end
      end
      S_EVAL: begin
        op.eval = 1'b1;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_key_d  = word_q;
          out_idx_d  = pos;
          out_last_d = 1'b1;
          out_size_d = fill_q;
          out_cnt_d  = '0;
          if (cmd_q == CMD_ADD) begin
            if (found) begin
              op.inc    = 1'b1;
              out_st_d  = ST_COUNTED;
              out_cnt_d = inc_cnt;
            end else if (fill_q == IDX_W'(TABLE_DEPTH)) begin
              out_st_d = ST_FULL;
            end else begin
              op.ins     = 1'b1;
              fill_d     = fill_q + IDX_W'(1);
              out_st_d   = ST_INSERTED;
              out_cnt_d  = COUNT_BITS'(1);
              out_size_d = fill_d;
            end
          end else begin
            if (found) begin
              op.del     = 1'b1;
              fill_d     = fill_q - IDX_W'(1);
              out_st_d   = ST_REMOVED;
              out_cnt_d  = match_cnt;
              out_size_d = fill_d;
            end else begin
              out_st_d = ST_NOT_FOUND;
            end
          end
          state_d = S_IDLE;
        end
      end
      S_DLOAD: begin
        if (fill_q == '0) begin
          // empty table answers one not-found result
          if (out_free) begin
            out_vld_d  = 1'b1;
            out_st_d   = ST_NOT_FOUND;
            out_key_d  = '0;
            out_cnt_d  = '0;
            out_idx_d  = '0;
            out_size_d = '0;
            out_last_d = 1'b1;
            state_d    = S_IDLE;
          end
        end else begin
          op.dload = 1'b1;
          rot_d    = '0;
          state_d  = S_ROT;
        end
      end
      S_ROT: begin
        op.rot = 1'b1;
        rot_d  = rot_q + POS_W'(1);
        if (rot_q == POS_W'(TABLE_DEPTH - 1)) begin
          rank_sel_d = '0;
          state_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_st_d   = ST_DUMP;
          out_key_d  = hit_key;
          out_cnt_d  = hit_cnt;
          out_idx_d  = rank_sel_q;
          out_size_d = fill_q;
          out_last_d = (rank_sel_q == fill_q - IDX_W'(1));
          rank_sel_d = rank_sel_q + IDX_W'(1);
          if (out_last_d) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_q     <= '0;
      rot_q      <= '0;
      rank_sel_q <= '0;
      out_vld_q  <= 1'b0;
      cmd_q      <= CMD_ADD;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      rot_q      <= rot_d;
      rank_sel_q <= rank_sel_d;
      out_vld_q  <= out_vld_d;
      cmd_q      <= cmd_d;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    out_st_q   <= out_st_d;
    out_key_q  <= out_key_d;
    out_cnt_q  <= out_cnt_d;
    out_idx_q  <= out_idx_d;
    out_size_q <= out_size_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_size_q, out_idx_q, 32'(out_cnt_q), 64'(out_key_q)};

  `SWFT_ASSERT_IMPLY(a_fill_bound, 1'b1, fill_q <= IDX_W'(TABLE_DEPTH), "fill above depth")
  `SWFT_ASSERT_IMPLY(a_pos_onehot, state_q == S_APPLY, $onehot0(first), "sort order broken")
  `SWFT_ASSERT_IMPLY(a_rank_unique, state_q == S_EMIT, $onehot(hit), "dump rank not unique")
  `SWFT_ASSERT_NEXT(a_insert_grows, state_q == S_APPLY && out_free && cmd_q == CMD_ADD && !found && fill_q != IDX_W'(TABLE_DEPTH), fill_q == $past(fill_q) + IDX_W'(1), "insert lost")

endmodule
